>>> hw/rtl/text_row_ring_editor_macros.svh
// Assertion macros for the text row ring editor.
// Define NO_ASSERTIONS to compile every check away.
`ifndef TEXT_ROW_RING_EDITOR_MACROS_SVH
`define TEXT_ROW_RING_EDITOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check on every clock edge, masked while reset is asserted.
`define TRRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every clock edge, reset included.
`define TRRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TRRE_ASSERT(lbl, prop, msg)
`define TRRE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hw/rtl/trre_pkg.sv
// Shared types, constants and key folding for the text row ring editor.
// No dependencies.
`timescale 1ns / 1ps

package trre_pkg;

  localparam int RowsDef = 5;
  localparam int ColsDef = 40;

  localparam int CharW  = 8;
  localparam int LimitW = 16;
  localparam int StepW  = 10;
  localparam int CfgW   = 16;

  localparam logic [CharW-1:0]  KeyBackspace = 8'h08;
  localparam logic [CharW-1:0]  KeyReturn    = 8'h0D;
  localparam logic [CharW-1:0]  CharSpace    = 8'h20;
  localparam logic [CharW-1:0]  CharNone     = 8'h00;
  localparam logic [LimitW-1:0] IdleLimitRst = 16'd5000;
  localparam logic [StepW-1:0]  TickStepRst  = 10'd16;
  localparam logic [LimitW-1:0] IdleMax      = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic {
    CFG_IDLE_LIMIT = 1'b0,
    CFG_TICK_STEP  = 1'b1
  } cfg_idx_e;

  // Control between the cursor logic and the character store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic rd_hit;
    logic closed;
  } mem_ctl_t;

  // Uppercase a-z and the three accented letters, blank control codes.
  function automatic logic [CharW-1:0] fold_key(input logic [CharW-1:0] k);
    logic [CharW-1:0] res;
    if ((k >= 8'h61 && k <= 8'h7A) || k == 8'hE4 || k == 8'hE5 || k == 8'hF6) begin
      res = k - 8'd32;
    end else if (k < 8'd32) begin
      res = CharSpace;
    end else begin
      res = k;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/trre_if.sv
// Valid/ready channel interfaces for the editor's item and result words.
// Depends on trre_pkg for the character width.
`timescale 1ns / 1ps

interface trre_in_if #(
  parameter int RowW = 3,
  parameter int ColW = 6
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 op;
  logic [trre_pkg::CharW-1:0] key_code;
  logic [RowW-1:0]            view_row;
  logic [ColW-1:0]            view_col;

  modport source (output valid, op, key_code, view_row, view_col, input ready);
  modport sink   (input valid, op, key_code, view_row, view_col, output ready);
endinterface

interface trre_out_if #(
  parameter int RowW = 3,
  parameter int ColW = 6
);
  logic                       valid;
  logic                       ready;
  logic [trre_pkg::CharW-1:0] read_char;
  logic [RowW-1:0]            cursor_row;
  logic [ColW-1:0]            cursor_col;
  logic                       row_closed;

  modport source (output valid, read_char, cursor_row, cursor_col, row_closed, input ready);
  modport sink   (input valid, read_char, cursor_row, cursor_col, row_closed, output ready);
endinterface

>>> hw/rtl/trre_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on trre_pkg for default sizes.
`timescale 1ns / 1ps

module trre_ram #(
  parameter int Width = trre_pkg::CharW,
  parameter int Depth = trre_pkg::RowsDef * trre_pkg::ColsDef,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/trre_ctrl.sv
// Cursor, row lengths, idle timer and configuration registers of the editor.
// Depends on trre_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "text_row_ring_editor_macros.svh"

module trre_ctrl #(
  parameter int ROWS = trre_pkg::RowsDef,
  parameter int COLS = trre_pkg::ColsDef,
  localparam int RowW  = $clog2(ROWS),
  localparam int ColW  = $clog2(COLS + 1),
  localparam int AddrW = $clog2(ROWS * COLS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [trre_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        acc_i,
  input  logic [1:0]                  op_i,
  input  logic [trre_pkg::CharW-1:0]  key_i,
  input  logic [RowW-1:0]             vrow_i,
  input  logic [ColW-1:0]             vcol_i,
  output trre_pkg::mem_ctl_t          mem_ctl_o,
  output logic [AddrW-1:0]            wr_addr_o,
  output logic [trre_pkg::CharW-1:0]  wr_data_o,
  output logic [AddrW-1:0]            rd_addr_o,
  output logic [RowW-1:0]             cursor_row_o,
  output logic [ColW-1:0]             cursor_col_o
);

  localparam logic [RowW-1:0]  LastRow = RowW'(ROWS - 1);
  localparam logic [RowW:0]    RowsW   = (RowW + 1)'(ROWS);
  localparam logic [ColW-1:0]  ColsC   = ColW'(COLS);
  localparam logic [AddrW-1:0] ColsA   = AddrW'(COLS);

  logic [trre_pkg::LimitW-1:0] idle_limit_q;
  logic [trre_pkg::StepW-1:0]  tick_step_q;
  logic [trre_pkg::LimitW-1:0] idle_q, idle_d;
  logic [RowW-1:0]             cur_row_q, cur_row_d;
  logic [ColW-1:0]             cur_col_q, cur_col_d;
  logic [ColW-1:0]             row_len_q [ROWS];
  logic [ColW-1:0]             row_len_d [ROWS];

  trre_pkg::op_e               op;
  logic [RowW-1:0]             next_row;
  logic [RowW-1:0]             prev_row;
  logic [RowW:0]               view_sum;
  logic [RowW-1:0]             view_phys;
  logic                        view_ok;
  logic [RowW-1:0]             len_sel;
  logic [ColW-1:0]             len_rd;
  logic [ColW-1:0]             col_inc;
  logic [trre_pkg::LimitW:0]   idle_sum;
  logic [trre_pkg::LimitW-1:0] idle_sat;

  assign op       = trre_pkg::op_e'(op_i);
  assign next_row = (cur_row_q == LastRow) ? '0 : cur_row_q + 1'b1;
  assign prev_row = (cur_row_q == '0) ? LastRow : cur_row_q - 1'b1;

  // Display row 0 is the row after the cursor, the oldest in the ring.
  assign view_ok   = {1'b0, vrow_i} < RowsW;
  assign view_sum  = {1'b0, cur_row_q} + {1'b0, vrow_i} + 1'b1;
  assign view_phys = (view_sum >= RowsW) ? RowW'(view_sum - RowsW) : RowW'(view_sum);

  // One length lookup per item: the display row on a read, else the previous row.
  assign len_sel = (op == trre_pkg::OP_READ) ? view_phys : prev_row;
  assign len_rd  = row_len_q[len_sel];

  assign col_inc  = cur_col_q + 1'b1;
  assign idle_sum = {1'b0, idle_q} + (trre_pkg::LimitW + 1)'(tick_step_q);
  assign idle_sat = idle_sum[trre_pkg::LimitW] ? trre_pkg::IdleMax
                                               : idle_sum[trre_pkg::LimitW-1:0];

  assign wr_addr_o = AddrW'(cur_row_q) * ColsA + AddrW'(cur_col_q);
  assign wr_data_o = trre_pkg::fold_key(key_i);
  assign rd_addr_o = AddrW'(view_phys) * ColsA + AddrW'(vcol_i);

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    idle_d    = idle_q;
    row_len_d = row_len_q;
    mem_ctl_o = '0;
    if (acc_i) begin
      unique case (op)
        trre_pkg::OP_KEY: begin
          idle_d = '0;
          if (key_i == trre_pkg::KeyBackspace) begin
            if (cur_col_q != '0) begin
              cur_col_d = cur_col_q - 1'b1;
              row_len_d[cur_row_q] = cur_col_q - 1'b1;
            end else begin
              cur_row_d = prev_row;
              cur_col_d = (len_rd != '0) ? len_rd - 1'b1 : '0;
              row_len_d[prev_row] = (len_rd != '0) ? len_rd - 1'b1 : '0;
            end
          end else begin
            mem_ctl_o.wr_en = 1'b1;
            row_len_d[cur_row_q] = col_inc;
            if (key_i == trre_pkg::KeyReturn || col_inc == ColsC) begin
              // End the row and open the next one empty.
              cur_row_d = next_row;
              cur_col_d = '0;
              row_len_d[next_row] = '0;
              mem_ctl_o.closed = 1'b1;
            end else begin
              cur_col_d = col_inc;
            end
          end
        end
        trre_pkg::OP_TICK: begin
          idle_d = idle_sat;
          if (cur_col_q != '0 && idle_sat > idle_limit_q) begin
            cur_row_d = next_row;
            cur_col_d = '0;
            mem_ctl_o.closed = 1'b1;
          end
        end
        trre_pkg::OP_READ: begin
          if (view_ok && vcol_i < len_rd) begin
            mem_ctl_o.rd_hit = 1'b1;
            mem_ctl_o.rd_en  = 1'b1;
          end
        end
        trre_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= trre_pkg::IdleLimitRst;
      tick_step_q  <= trre_pkg::TickStepRst;
      idle_q       <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      for (int r = 0; r < ROWS; r++) begin
        row_len_q[r] <= ColsC;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (trre_pkg::cfg_idx_e'(cfg_idx_i))
          trre_pkg::CFG_IDLE_LIMIT: idle_limit_q <= cfg_data_i;
          trre_pkg::CFG_TICK_STEP:  tick_step_q  <= cfg_data_i[trre_pkg::StepW-1:0];
          default: begin
          end
        endcase
      end
      idle_q    <= idle_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      row_len_q <= row_len_d;
    end
  end

  assign cursor_row_o = cur_row_d;
  assign cursor_col_o = cur_col_d;

  `TRRE_ASSERT(a_col_in_row, cur_col_q < ColsC, "cursor column past row end")
  `TRRE_ASSERT(a_row_in_ring, {1'b0, cur_row_q} < RowsW, "cursor row outside ring")
  `TRRE_ASSERT(a_close_home, mem_ctl_o.closed |=> cur_col_q == '0, "closed row left col")
  `TRRE_ASSERT(a_key_trunc, (acc_i && op == trre_pkg::OP_KEY) |=> row_len_q[cur_row_q] == cur_col_q, "key did not truncate row at cursor")
  `TRRE_ASSERT(a_hit_in_len, mem_ctl_o.rd_hit |-> vcol_i < ColsC, "read hit beyond columns")

endmodule

>>> hw/rtl/text_row_ring_editor.sv
// Text row ring editor: an accepted item word has its result word in the next cycle.
// Throughput: one item per cycle unless stalled; the result register frees when taken.
// The character store is a RAM with registered read; per-entry valid flip-flops stand
// in for the all-spaces fill, so the block is ready right after reset.
// Reset (rst_ni low, asynchronous): cursor home, every row full length, idle timer 0,
// idle_limit 5000, tick_step 16, no result pending.
`timescale 1ns / 1ps

module text_row_ring_editor #(
  parameter int ROWS = trre_pkg::RowsDef,
  parameter int COLS = trre_pkg::ColsDef,
  localparam int RowW  = $clog2(ROWS),
  localparam int ColW  = $clog2(COLS + 1),
  localparam int Depth = ROWS * COLS,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  trre_in_if.sink                   in_ch,
  trre_out_if.source                out_ch,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [trre_pkg::CfgW-1:0] cfg_data_i
);

  trre_pkg::mem_ctl_t         mem_ctl;
  logic [AddrW-1:0]           wr_addr;
  logic [AddrW-1:0]           rd_addr;
  logic [trre_pkg::CharW-1:0] wr_data;
  logic [trre_pkg::CharW-1:0] rd_data;
  logic [RowW-1:0]            cursor_row;
  logic [ColW-1:0]            cursor_col;
  logic                       acc;

  logic                       vld_q [Depth];
  logic                       out_vld_q;
  logic                       hit_q;
  logic                       written_q;
  logic [RowW-1:0]            cursor_row_q;
  logic [ColW-1:0]            cursor_col_q;
  logic                       closed_q;

  assign in_ch.ready = !out_vld_q || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  trre_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .acc_i        (acc),
    .op_i         (in_ch.op),
    .key_i        (in_ch.key_code),
    .vrow_i       (in_ch.view_row),
    .vcol_i       (in_ch.view_col),
    .mem_ctl_o    (mem_ctl),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_addr_o    (rd_addr),
    .cursor_row_o (cursor_row),
    .cursor_col_o (cursor_col)
  );

  trre_ram #(
    .Width (trre_pkg::CharW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (mem_ctl.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // An entry never typed over reads as a space.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (mem_ctl.wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      if (acc) begin
        out_vld_q <= 1'b1;
        hit_q     <= mem_ctl.rd_hit;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the result word until the sink takes it.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cursor_row_q <= cursor_row;
      cursor_col_q <= cursor_col;
      closed_q     <= mem_ctl.closed;
      if (mem_ctl.rd_hit) begin
        written_q <= vld_q[rd_addr];
      end
    end
  end

  assign out_ch.valid      = out_vld_q;
  assign out_ch.read_char  = !hit_q    ? trre_pkg::CharNone
                           : written_q ? rd_data
                           :             trre_pkg::CharSpace;
  assign out_ch.cursor_row = cursor_row_q;
  assign out_ch.cursor_col = cursor_col_q;
  assign out_ch.row_closed = closed_q;

endmodule

>>> test/text_row_ring_editor_check.sv
// Checker for the text row ring editor: watches the item, result and register ports.
// Predicts each result word and compares it with the block's output.
// Depends on trre_pkg and the channel interfaces in trre_if.sv.
`timescale 1ns / 1ps

module text_row_ring_editor_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  trre_in_if                           in_ch,
  trre_out_if                          out_ch,
  input  logic                         cfg_we_i,
  input  trre_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [trre_pkg::CfgW-1:0]    cfg_data_i,
  output int unsigned                  pending_o,
  output int unsigned                  mismatch_o
);
  import trre_pkg::*;

  localparam int Rows = RowsDef;
  localparam int Cols = ColsDef;

  typedef struct packed {
    logic [7:0] rd_char;
    logic [2:0] row;
    logic [5:0] col;
    logic       closed;
  } cursor_word_t;

  cursor_word_t cursor_words_q[$];

  logic [7:0] screen_mem [Rows*Cols];
  int         line_len [Rows];
  int         row_pos;
  int         col_pos;
  int         idle_ms;
  int         limit_ms;
  int         step_ms;

  int unsigned pending_cnt  = 0;
  int unsigned mismatch_cnt = 0;

  assign pending_o  = pending_cnt;
  assign mismatch_o = mismatch_cnt;

  // Letters and the three accented codes all carry bit 5; clearing it uppercases.
  function automatic logic [7:0] upcase_key(input logic [7:0] k);
    if ((k >= 8'h61 && k <= 8'h7A) || k == 8'hE4 || k == 8'hE5 || k == 8'hF6) begin
      return k & ~8'h20;
    end
    if (k < 8'h20) begin
      return CharSpace;
    end
    return k;
  endfunction

  function automatic cursor_word_t edit_step(input op_e op, input logic [7:0] key,
                                             input logic [2:0] vrow, input logic [5:0] vcol);
    cursor_word_t w;
    int phys;
    w = '0;
    case (op)
      OP_KEY: begin
        idle_ms = 0;
        if (key == KeyBackspace) begin
          if (col_pos > 0) begin
            col_pos--;
          end else begin
            row_pos = (row_pos == 0) ? Rows - 1 : row_pos - 1;
            col_pos = (line_len[row_pos] > 0) ? line_len[row_pos] - 1 : 0;
          end
          line_len[row_pos] = col_pos;
        end else begin
          screen_mem[row_pos*Cols + col_pos] = upcase_key(key);
          col_pos++;
          line_len[row_pos] = col_pos;
          if (key == KeyReturn || col_pos >= Cols) begin
            row_pos = (row_pos + 1) % Rows;
            col_pos = 0;
            line_len[row_pos] = 0;
            w.closed = 1'b1;
          end
        end
      end
      OP_TICK: begin
        idle_ms = idle_ms + step_ms;
        if (idle_ms > 65535) begin
          idle_ms = 65535;
        end
        // close the row, keep the next row's old text and length
        if (col_pos > 0 && idle_ms > limit_ms) begin
          row_pos = (row_pos + 1) % Rows;
          col_pos = 0;
          w.closed = 1'b1;
        end
      end
      OP_READ: begin
        if (vrow < Rows) begin
          phys = (row_pos + 1 + vrow) % Rows;
          if (vcol < line_len[phys]) begin
            w.rd_char = screen_mem[phys*Cols + vcol];
          end
        end
      end
      default: ;
    endcase
    w.row = 3'(row_pos);
    w.col = 6'(col_pos);
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cursor_word_t want;
    if (!rst_ni) begin
      cursor_words_q.delete();
      pending_cnt = 0;
      row_pos = 0;
      col_pos = 0;
      idle_ms = 0;
      limit_ms = int'(IdleLimitRst);
      step_ms = int'(TickStepRst);
      for (int r = 0; r < Rows; r++) begin
        line_len[r] = Cols;
      end
      for (int i = 0; i < Rows*Cols; i++) begin
        screen_mem[i] = CharSpace;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDLE_LIMIT) begin
          limit_ms = int'(cfg_data_i[LimitW-1:0]);
        end else begin
          step_ms = int'(cfg_data_i[StepW-1:0]);
        end
      end
      // retire the result word before predicting the new item word
      if (out_ch.valid && out_ch.ready) begin
        if (cursor_words_q.size() == 0) begin
          $error("result word with no item waiting: read_char 0x%02h row %0d col %0d",
                 out_ch.read_char, out_ch.cursor_row, out_ch.cursor_col);
          mismatch_cnt++;
        end else begin
          want = cursor_words_q.pop_front();
          if (out_ch.read_char !== want.rd_char) begin
            $error("read_char: expected 0x%02h, got 0x%02h", want.rd_char, out_ch.read_char);
            mismatch_cnt++;
          end
          if (out_ch.cursor_row !== want.row) begin
            $error("cursor_row: expected %0d, got %0d", want.row, out_ch.cursor_row);
            mismatch_cnt++;
          end
          if (out_ch.cursor_col !== want.col) begin
            $error("cursor_col: expected %0d, got %0d", want.col, out_ch.cursor_col);
            mismatch_cnt++;
          end
          if (out_ch.row_closed !== want.closed) begin
            $error("row_closed: expected %0b, got %0b", want.closed, out_ch.row_closed);
            mismatch_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cursor_words_q = {cursor_words_q, edit_step(op_e'(in_ch.op), in_ch.key_code,
                                                    in_ch.view_row, in_ch.view_col)};
      end
      pending_cnt = cursor_words_q.size();
    end
  end

endmodule

>>> test/text_row_ring_editor_tb.sv
// Top of the text row ring editor testbench: clock, reset, item stimulus, register writes.
// Instantiates the block and text_row_ring_editor_check; depends on trre_pkg and trre_if.sv.
`timescale 1ns / 1ps

module text_row_ring_editor_tb;
  import trre_pkg::*;

  localparam int Rows       = RowsDef;
  localparam int Cols       = ColsDef;
  localparam int RowW       = $clog2(Rows);
  localparam int ColW       = $clog2(Cols + 1);
  localparam int CycleLimit = 400000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  cfg_idx_e        cfg_idx = CFG_IDLE_LIMIT;
  logic [CfgW-1:0] cfg_data = '0;

  bit          steady = 1'b0;
  int unsigned words_sent = 0;
  int unsigned cycle_cnt = 0;
  int unsigned pending;
  int unsigned mismatches;

  trre_in_if  #(.RowW(RowW), .ColW(ColW)) in_ch ();
  trre_out_if #(.RowW(RowW), .ColW(ColW)) out_ch ();

  text_row_ring_editor #(.ROWS(Rows), .COLS(Cols)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  text_row_ring_editor_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .mismatch_o (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("text_row_ring_editor test failed");
      $finish;
    end
  end

  // Stall the result side at random, never while the steady phase runs.
  always @(negedge clk_i) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 38);
  end

  task automatic send_word(input op_e op, input logic [7:0] key,
                           input logic [2:0] vrow, input logic [5:0] vcol);
    while (!steady && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.key_code <= key;
    in_ch.view_row <= vrow;
    in_ch.view_col <= vcol;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic press(input logic [7:0] key);
    send_word(OP_KEY, key, 3'($urandom), 6'($urandom));
  endtask

  task automatic tick_once();
    send_word(OP_TICK, 8'($urandom), 3'($urandom), 6'($urandom));
  endtask

  task automatic read_cell(input logic [2:0] vrow, input logic [5:0] vcol);
    send_word(OP_READ, 8'($urandom), vrow, vcol);
  endtask

  // Drain all results, then load both registers.
  task automatic set_timing(input logic [LimitW-1:0] limit, input logic [StepW-1:0] step);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx  <= CFG_IDLE_LIMIT;
    cfg_data <= CfgW'(limit);
    @(negedge clk_i);
    cfg_idx  <= CFG_TICK_STEP;
    cfg_data <= CfgW'(step);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] random_key();
    logic [7:0] odd_keys [6] = '{8'hE4, 8'hE5, 8'hF6, 8'hFF, 8'h00, 8'h1F};
    case ($urandom_range(3))
      0:       return 8'($urandom_range(8'h7A, 8'h61));
      1:       return 8'($urandom_range(255));
      2:       return odd_keys[$urandom_range(5)];
      default: return 8'($urandom_range(8'h7E, 8'h20));
    endcase
  endfunction

  task automatic random_words(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    goal = words_sent + count;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // typed line, sometimes long enough to fill the row
        len = $urandom_range(45);
        repeat (len) begin
          if ($urandom_range(9) == 0) begin
            press(KeyBackspace);
          end else begin
            press(random_key());
          end
        end
        if ($urandom_range(3) != 0) begin
          press(KeyReturn);
        end
      end else if (pick < 53) begin
        // erase backward, far enough to wrap around the ring
        repeat ($urandom_range(90, 1)) press(KeyBackspace);
      end else if (pick < 68) begin
        repeat ($urandom_range(80, 1)) tick_once();
      end else if (pick < 90) begin
        repeat ($urandom_range(8, 1)) begin
          read_cell(($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(Rows-1)),
                    ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(Cols-1)));
        end
      end else begin
        send_word(op_e'($urandom_range(3)), 8'($urandom), 3'($urandom), 6'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_NOP;
    in_ch.key_code = '0;
    in_ch.view_row = '0;
    in_ch.view_col = '0;
    out_ch.ready   = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // untouched store reads as spaces; rows and columns out of range read as zero
    read_cell(3'd0, 6'd0);
    read_cell(3'd4, 6'd39);
    read_cell(3'd7, 6'd0);
    read_cell(3'd5, 6'd63);
    // folding: lowercase, accented letters, control codes, neighbors of the ranges
    press(8'h61);
    press(8'h7A);
    press(8'hE4);
    press(8'hE5);
    press(8'hF6);
    press(8'h00);
    press(8'h1F);
    press(8'hFF);
    press(8'h7B);
    press(8'h60);
    press(KeyBackspace);
    press(KeyBackspace);
    press(KeyReturn);
    // backspace at column zero climbs to the end of the previous row
    press(KeyBackspace);
    read_cell(3'd3, 6'd2);
    read_cell(3'd4, 6'd0);
    send_word(OP_NOP, 8'hFF, 3'd7, 6'd63);
    tick_once();
    tick_once();
    random_words(220);

    // every tick closes a non-empty row
    set_timing(16'd0, 10'd1023);
    press(8'h71);
    tick_once();
    tick_once();
    random_words(200);

    // timer saturates and never passes the highest limit
    set_timing(16'hFFFF, 10'd1023);
    press(8'h71);
    repeat (70) tick_once();
    random_words(200);

    // timer frozen; no idling on either side
    steady = 1'b1;
    set_timing(16'd0, 10'd0);
    random_words(200);
    steady = 1'b0;

    set_timing(16'($urandom_range(3000, 100)), 10'($urandom_range(300, 1)));
    random_words(200);

    set_timing(16'd1, 10'd1);
    random_words(200);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("text_row_ring_editor test passed");
    end else begin
      $display("text_row_ring_editor test failed");
    end
    $finish;
  end

endmodule
